// ----- design/acc_pkg.sv -----
// ----------------------------------------------------------------------------
// Alarm clock controller package
// Event and key codes, display modes, field limits and shared types.
// ----------------------------------------------------------------------------
package acc_pkg;

  // Event kinds carried in the input tuser.
  localparam logic [1:0] KindKey    = 2'd0;
  localparam logic [1:0] KindSecond = 2'd1;
  localparam logic [1:0] KindFlash  = 2'd2;

  // Key codes.
  localparam logic [2:0] KeyNext = 3'd1;
  localparam logic [2:0] KeyUp   = 3'd2;
  localparam logic [2:0] KeyDown = 3'd3;
  localparam logic [2:0] KeySet  = 3'd4;

  // Display modes.
  localparam logic [1:0] ShowClock = 2'd0;
  localparam logic [1:0] ShowAlarm = 2'd1;
  localparam logic [1:0] ShowTemp  = 2'd2;

  // Field selects.
  localparam logic [1:0] FieldHour   = 2'd0;
  localparam logic [1:0] FieldMinute = 2'd1;
  localparam logic [1:0] FieldSecond = 2'd2;

  localparam logic [4:0] HourTop = 5'd23;
  localparam logic [5:0] MinTop  = 6'd59;

  localparam logic [7:0] FlashTogglesReset = 8'd10;

  localparam int unsigned OutWidth = 24;

  // Next LED and ringing state, handed from the ring controller to the top.
  typedef struct packed {
    logic active;
    logic led;
  } ring_t;

  // Steps a time field up or down by one with wrap around its top value.
  function automatic logic [5:0] step_field(input logic [5:0] v, input logic [5:0] top,
                                            input logic up);
    logic [5:0] r;
    if (up) begin
      r = (v >= top) ? 6'd0 : v + 6'd1;
    end else begin
      r = ((v == 6'd0) || (v > top)) ? top : v - 6'd1;
    end
    return r;
  endfunction

endpackage

// ----- design/acc_ring_ctrl.sv -----
// ----------------------------------------------------------------------------
// Alarm ring controller
// Holds the ringing flag, the active-low LED level and the toggle counter.
// ----------------------------------------------------------------------------
module acc_ring_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          flash_i,   // flash tick event accepted this cycle
  input  logic          match_i,   // clock equals alarm after this event
  input  logic [7:0]    limit_i,   // toggles per ringing
  output acc_pkg::ring_t ring_d_o  // state after this cycle's event
);

  logic       active_q, active_d;
  logic       led_q, led_d;
  logic [7:0] count_q, count_d;
  logic [7:0] count_inc;

  assign count_inc = count_q + 8'd1;

  always_comb begin
    active_d = active_q;
    led_d    = led_q;
    count_d  = count_q;
    if (flash_i && active_q) begin
      led_d   = ~led_q;
      count_d = count_inc;
      // A limit of zero behaves as one since the count is already one here.
      if (count_inc >= limit_i) begin
        active_d = 1'b0;
        count_d  = 8'd0;
      end
    end
    if (match_i) begin
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      led_q    <= 1'b1;
      count_q  <= 8'd0;
    end else begin
      active_q <= active_d;
      led_q    <= led_d;
      count_q  <= count_d;
    end
  end

  assign ring_d_o.active = active_d;
  assign ring_d_o.led    = led_d;

endmodule

// ----- design/alarm_clock_controller_core.sv -----
// ----------------------------------------------------------------------------
// Alarm clock controller core
// Keeps time, alarm, edit buffer and display state; one event per transfer.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Signals                                 Content
//   s_axis    in   tvalid/tready/tdata[7:0]/tuser[1:0]     key code, event kind
//   m_axis    out  tvalid/tready/tdata[23:0]               display and alarm status
//   cfg       in   cfg_valid/cfg_ready/cfg_data[7:0]       LED toggles per ringing
//
// Each event is applied in the cycle of its transfer and its result lands in
// the output register on the same edge, so one event per cycle is sustained while
// m_axis is ready. The output register frees itself when taken, letting the next
// transfer in the same cycle; a stalled m_axis holds s_axis_tready_o low.
// Reset sets the clock to 23:59:59, the alarm to 00:00:00 and ten toggles.
// ----------------------------------------------------------------------------
module alarm_clock_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [2:0] key_code, [7:3] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] event kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] show_mode, [2] editing, [4:3] edit_field, [9:5] shown_hour,
  // [15:10] shown_minute, [21:16] shown_second, [22] alarm_ringing, [23] led_level
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic accept;
  logic [1:0] kind;
  logic [2:0] key;

  logic [7:0] limit_q;

  logic [4:0] clk_hour_q, clk_hour_d;
  logic [5:0] clk_min_q, clk_min_d;
  logic [5:0] clk_sec_q, clk_sec_d;
  logic [4:0] alm_hour_q, alm_hour_d;
  logic [5:0] alm_min_q, alm_min_d;
  logic [5:0] alm_sec_q, alm_sec_d;
  logic [4:0] buf_hour_q, buf_hour_d;
  logic [5:0] buf_min_q, buf_min_d;
  logic [5:0] buf_sec_q, buf_sec_d;
  logic [1:0] show_q, show_d;
  logic       edit_q, edit_d;
  logic [1:0] field_q, field_d;

  logic flash_ev;
  logic match;
  acc_pkg::ring_t ring_d;

  logic [4:0] shown_hour;
  logic [5:0] shown_min;
  logic [5:0] shown_sec;

  logic                          out_valid_q, out_valid_d;
  logic [acc_pkg::OutWidth-1:0]  out_data_q;

  assign kind   = s_axis_tuser_i;
  assign key    = s_axis_tdata_i[2:0];
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    clk_hour_d = clk_hour_q;
    clk_min_d  = clk_min_q;
    clk_sec_d  = clk_sec_q;
    alm_hour_d = alm_hour_q;
    alm_min_d  = alm_min_q;
    alm_sec_d  = alm_sec_q;
    buf_hour_d = buf_hour_q;
    buf_min_d  = buf_min_q;
    buf_sec_d  = buf_sec_q;
    show_d     = show_q;
    edit_d     = edit_q;
    field_d    = field_q;
    flash_ev   = 1'b0;
    if (accept) begin
      case (kind)
        acc_pkg::KindKey: begin
          case (key)
            acc_pkg::KeyNext: begin
              if (edit_q) begin
                field_d = (field_q >= acc_pkg::FieldSecond) ? acc_pkg::FieldHour
                                                            : field_q + 2'd1;
              end else begin
                show_d = (show_q >= acc_pkg::ShowTemp) ? acc_pkg::ShowClock
                                                       : show_q + 2'd1;
              end
            end
            acc_pkg::KeyUp, acc_pkg::KeyDown: begin
              if (edit_q) begin
                case (field_q)
                  acc_pkg::FieldMinute:
                    buf_min_d = acc_pkg::step_field(buf_min_q, acc_pkg::MinTop,
                                                    key == acc_pkg::KeyUp);
                  acc_pkg::FieldSecond:
                    buf_sec_d = acc_pkg::step_field(buf_sec_q, acc_pkg::MinTop,
                                                    key == acc_pkg::KeyUp);
                  default:
                    buf_hour_d = 5'(acc_pkg::step_field({1'b0, buf_hour_q},
                                                        {1'b0, acc_pkg::HourTop},
                                                        key == acc_pkg::KeyUp));
                endcase
              end
            end
            acc_pkg::KeySet: begin
              if (edit_q) begin
                if (show_q == acc_pkg::ShowClock) begin
                  clk_hour_d = buf_hour_q;
                  clk_min_d  = buf_min_q;
                  clk_sec_d  = buf_sec_q;
                end else if (show_q == acc_pkg::ShowAlarm) begin
                  alm_hour_d = buf_hour_q;
                  alm_min_d  = buf_min_q;
                  alm_sec_d  = buf_sec_q;
                end
                edit_d = 1'b0;
              end else if (show_q == acc_pkg::ShowClock) begin
                buf_hour_d = clk_hour_q;
                buf_min_d  = clk_min_q;
                buf_sec_d  = clk_sec_q;
                edit_d     = 1'b1;
              end else if (show_q == acc_pkg::ShowAlarm) begin
                buf_hour_d = alm_hour_q;
                buf_min_d  = alm_min_q;
                buf_sec_d  = alm_sec_q;
                edit_d     = 1'b1;
              end
            end
            default: ;
          endcase
        end
        acc_pkg::KindSecond: begin
          if (clk_sec_q >= acc_pkg::MinTop) begin
            clk_sec_d = 6'd0;
            if (clk_min_q >= acc_pkg::MinTop) begin
              clk_min_d  = 6'd0;
              clk_hour_d = (clk_hour_q >= acc_pkg::HourTop) ? 5'd0 : clk_hour_q + 5'd1;
            end else begin
              clk_min_d = clk_min_q + 6'd1;
            end
          end else begin
            clk_sec_d = clk_sec_q + 6'd1;
          end
        end
        acc_pkg::KindFlash: flash_ev = 1'b1;
        default: ;
      endcase
    end
  end

  // The alarm is compared after every event, including ones that change nothing.
  assign match = accept && (clk_hour_d == alm_hour_d) && (clk_min_d == alm_min_d) &&
                 (clk_sec_d == alm_sec_d);

  acc_ring_ctrl u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .flash_i  (flash_ev),
    .match_i  (match),
    .limit_i  (limit_q),
    .ring_d_o (ring_d)
  );

  always_comb begin
    shown_hour = 5'd0;
    shown_min  = 6'd0;
    shown_sec  = 6'd0;
    if (edit_d) begin
      shown_hour = buf_hour_d;
      shown_min  = buf_min_d;
      shown_sec  = buf_sec_d;
    end else if (show_d == acc_pkg::ShowClock) begin
      shown_hour = clk_hour_d;
      shown_min  = clk_min_d;
      shown_sec  = clk_sec_d;
    end else if (show_d == acc_pkg::ShowAlarm) begin
      shown_hour = alm_hour_d;
      shown_min  = alm_min_d;
      shown_sec  = alm_sec_d;
    end
  end

  assign out_valid_d = accept || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= acc_pkg::FlashTogglesReset;
      clk_hour_q  <= acc_pkg::HourTop;
      clk_min_q   <= acc_pkg::MinTop;
      clk_sec_q   <= acc_pkg::MinTop;
      alm_hour_q  <= 5'd0;
      alm_min_q   <= 6'd0;
      alm_sec_q   <= 6'd0;
      show_q      <= acc_pkg::ShowClock;
      edit_q      <= 1'b0;
      field_q     <= acc_pkg::FieldHour;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      clk_hour_q  <= clk_hour_d;
      clk_min_q   <= clk_min_d;
      clk_sec_q   <= clk_sec_d;
      alm_hour_q  <= alm_hour_d;
      alm_min_q   <= alm_min_d;
      alm_sec_q   <= alm_sec_d;
      show_q      <= show_d;
      edit_q      <= edit_d;
      field_q     <= field_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The edit buffer is always loaded before it is shown or committed.
  always_ff @(posedge clk_i) begin
    buf_hour_q <= buf_hour_d;
    buf_min_q  <= buf_min_d;
    buf_sec_q  <= buf_sec_d;
    if (accept) begin
      out_data_q <= {ring_d.led, ring_d.active, shown_sec, shown_min, shown_hour,
                     field_d, edit_d, show_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ----- tb/sv/tb_alarm_clock_controller_core.sv -----
// ----------------------------------------------------------------------------
// Alarm clock controller core testbench
// Drives key, second and flash events into the core with random gaps on both
// streams and checks every status word against a cycle-free model of the
// clock, alarm, edit and ringing logic. A short table of directed events comes
// first. Random phases follow, each under its own flash toggle limit, and
// they mix noise with key sequences that steer the clock onto the alarm.
// ----------------------------------------------------------------------------
module tb_alarm_clock_controller_core;
  import acc_pkg::*;

  localparam logic [1:0] KindUnused  = 2'd3;
  localparam logic [2:0] KeyNone     = 3'd0;
  localparam logic [2:0] KeyUnusedLo = 3'd5;
  localparam logic [2:0] KeyUnusedHi = 3'd7;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned PhaseItems = 465;
  localparam int unsigned DayTicks   = 86400;

  // Mirrors the m_axis tdata layout, highest bit first.
  typedef struct packed {
    logic       led;
    logic       ring;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [1:0] field;
    logic       editing;
    logic [1:0] show;
  } status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] key;
    logic       has_lit;
    status_t    lit;
  } clock_event_t;

  localparam status_t AtReset    = '{1'b1, 1'b0, 6'd59, 6'd59, 5'd23, FieldHour, 1'b0,
                                     ShowClock};
  localparam status_t AtMidnight = '{1'b1, 1'b1, 6'd0, 6'd0, 5'd0, FieldHour, 1'b0,
                                     ShowClock};

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;   // [2:0] key_code, [7:3] zero
  logic [1:0]  s_axis_tuser_i  = '0;   // [1:0] event kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [1:0] show_mode, [2] editing, [4:3] edit_field, [9:5] shown_hour,
  // [15:10] shown_minute, [21:16] shown_second, [22] alarm_ringing, [23] led_level
  logic [23:0] m_axis_tdata_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i      = '0;

  alarm_clock_controller_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Model state of the controller.
  logic [4:0] clk_hour = 5'd23;
  logic [5:0] clk_min = 6'd59;
  logic [5:0] clk_sec = 6'd59;
  logic [5:0] alarm_val [3] = '{6'd0, 6'd0, 6'd0};
  logic [5:0] edit_val [3] = '{6'd0, 6'd0, 6'd0};
  logic [1:0] disp_mode = ShowClock;
  logic       edit_on = 1'b0;
  logic [1:0] sel_field = FieldHour;
  logic       ringing = 1'b0;
  logic       led = 1'b1;
  logic [7:0] flash_cnt = 8'd0;
  logic [7:0] flash_limit = FlashTogglesReset;

  clock_event_t event_q [$];
  status_t      pending_status [$];
  clock_event_t cur_event;
  status_t      next_status;
  logic         tx_busy = 1'b0;
  logic         quiet = 1'b0;
  logic         long_hold_done = 1'b0;
  int unsigned  tx_gap = 0;
  int unsigned  rx_hold = 0;
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  events_taken = 0;
  int unsigned  results_checked = 0;
  int unsigned  phase_count = 0;
  int unsigned  ring_starts = 0;
  int unsigned  ring_stops = 0;
  int unsigned  steered = 0;
  logic [7:0]   mid_limit;

  clock_event_t directed_rows [0:25] = '{
    '{KindKey,    KeyNone,     1'b1, AtReset},
    '{KindUnused, KeyUnusedHi, 1'b1, AtReset},
    '{KindKey,    KeyUp,       1'b1, AtReset},
    '{KindKey,    KeyDown,     1'b1, AtReset},
    '{KindKey,    KeyUnusedLo, 1'b1, AtReset},
    // The first second rolls the clock over to midnight, which is the alarm.
    '{KindSecond, KeyNone,     1'b1, AtMidnight},
    '{KindFlash,  KeyNone,     1'b0, '0},
    '{KindSecond, KeyNone,     1'b0, '0},
    '{KindKey,    KeyNext,     1'b0, '0},
    '{KindKey,    KeySet,      1'b0, '0},
    '{KindKey,    KeyDown,     1'b0, '0},
    '{KindKey,    KeyNext,     1'b0, '0},
    '{KindKey,    KeyDown,     1'b0, '0},
    '{KindKey,    KeyUp,       1'b0, '0},
    '{KindKey,    KeyNext,     1'b0, '0},
    '{KindKey,    KeyUp,       1'b0, '0},
    '{KindKey,    KeyNext,     1'b0, '0},
    '{KindKey,    KeyUp,       1'b0, '0},
    '{KindKey,    KeySet,      1'b0, '0},
    '{KindFlash,  KeyNone,     1'b0, '0},
    '{KindKey,    KeyNext,     1'b0, '0},
    '{KindKey,    KeySet,      1'b0, '0},
    '{KindKey,    KeyNext,     1'b0, '0},
    '{KindKey,    KeySet,      1'b0, '0},
    '{KindSecond, KeyNone,     1'b0, '0},
    '{KindKey,    KeySet,      1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Applies one event to the model state and returns the status word that follows.
  function automatic status_t apply_clock_event(logic [1:0] kind, logic [2:0] key);
    logic [1:0] f;
    logic [5:0] top;
    status_t    st;
    f = (sel_field > FieldSecond) ? FieldHour : sel_field;
    top = (f == FieldHour) ? 6'(HourTop) : MinTop;
    case (kind)
      KindKey: begin
        if (key == KeyNext) begin
          if (edit_on) sel_field = (f == FieldSecond) ? FieldHour : f + 2'd1;
          else disp_mode = (disp_mode >= ShowTemp) ? ShowClock : disp_mode + 2'd1;
        end else if (key == KeyUp && edit_on) begin
          edit_val[f] = (edit_val[f] >= top) ? 6'd0 : edit_val[f] + 6'd1;
        end else if (key == KeyDown && edit_on) begin
          edit_val[f] = (edit_val[f] == 6'd0 || edit_val[f] > top) ? top : edit_val[f] - 6'd1;
        end else if (key == KeySet) begin
          if (edit_on) begin
            if (disp_mode == ShowClock) begin
              clk_hour = edit_val[0][4:0];
              clk_min = edit_val[1];
              clk_sec = edit_val[2];
            end else if (disp_mode == ShowAlarm) begin
              alarm_val = edit_val;
            end
            edit_on = 1'b0;
          end else if (disp_mode == ShowClock) begin
            edit_val = '{6'(clk_hour), clk_min, clk_sec};
            edit_on = 1'b1;
          end else if (disp_mode == ShowAlarm) begin
            edit_val = alarm_val;
            edit_on = 1'b1;
          end
        end
      end
      KindSecond: begin
        if (clk_sec == MinTop) begin
          clk_sec = 6'd0;
          if (clk_min == MinTop) begin
            clk_min = 6'd0;
            clk_hour = (clk_hour == HourTop) ? 5'd0 : clk_hour + 5'd1;
          end else begin
            clk_min = clk_min + 6'd1;
          end
        end else begin
          clk_sec = clk_sec + 6'd1;
        end
      end
      KindFlash: begin
        if (ringing) begin
          led = ~led;
          flash_cnt = flash_cnt + 8'd1;
          if (flash_cnt >= flash_limit) begin
            ringing = 1'b0;
            flash_cnt = 8'd0;
            ring_stops++;
          end
        end
      end
      default: ;
    endcase
    // The match is tested after every event, so a held match restarts ringing.
    if (6'(clk_hour) == alarm_val[0] && clk_min == alarm_val[1] && clk_sec == alarm_val[2])
    begin
      if (!ringing) ring_starts++;
      ringing = 1'b1;
    end
    st = '0;
    st.show = disp_mode;
    st.editing = edit_on;
    st.field = sel_field;
    st.ring = ringing;
    st.led = led;
    if (edit_on) begin
      st.hour = edit_val[0][4:0];
      st.minute = edit_val[1];
      st.second = edit_val[2];
    end else if (disp_mode == ShowClock) begin
      st.hour = clk_hour;
      st.minute = clk_min;
      st.second = clk_sec;
    end else if (disp_mode == ShowAlarm) begin
      st.hour = alarm_val[0][4:0];
      st.minute = alarm_val[1];
      st.second = alarm_val[2];
    end
    return st;
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic compare_status(status_t exp_s, status_t act_s);
    compare_field("show_mode", exp_s.show, act_s.show);
    compare_field("editing", exp_s.editing, act_s.editing);
    compare_field("edit_field", exp_s.field, act_s.field);
    compare_field("shown_hour", exp_s.hour, act_s.hour);
    compare_field("shown_minute", exp_s.minute, act_s.minute);
    compare_field("shown_second", exp_s.second, act_s.second);
    compare_field("alarm_ringing", exp_s.ring, act_s.ring);
    compare_field("led_level", exp_s.led, act_s.led);
  endtask

  // Event stream: the model advances on each accepted transfer.
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      next_status = apply_clock_event(cur_event.kind, cur_event.key);
      pending_status.push_back(cur_event.has_lit ? cur_event.lit : next_status);
      events_taken++;
      tx_busy = 1'b0;
    end
    if (!tx_busy) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (event_q.size() > 0) begin
        cur_event = event_q.pop_front();
        s_axis_tuser_i <= cur_event.kind;
        s_axis_tdata_i <= {5'd0, cur_event.key};
        tx_busy = 1'b1;
        tx_gap = quiet ? 0 : pick_gap();
      end
    end
    s_axis_tvalid_i <= tx_busy;
  end

  // Status stream: checks each transfer and stalls at random.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected status, expected none, actual %h", $time, m_axis_tdata_o);
      end else begin
        compare_status(pending_status.pop_front(), status_t'(m_axis_tdata_o));
      end
      results_checked++;
    end
    if (!long_hold_done && event_q.size() > 20) begin
      // One long stall while events keep coming, so the core backs up.
      rx_hold = 300;
      long_hold_done = 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      rx_hold = pick_gap();
    end
    m_axis_tready_i <= (rx_hold == 0);
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (event_q.size() != 0 || tx_busy || pending_status.size() != 0);
  endtask

  task automatic queue_event(logic [1:0] kind, logic [2:0] key);
    clock_event_t ev;
    ev = '{kind, key, 1'b0, '0};
    event_q.push_back(ev);
    phase_count++;
  endtask

  task automatic write_flash_limit(logic [7:0] value);
    wait_idle();
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    flash_limit = value;
  endtask

  task automatic queue_noise(int unsigned n, int unsigned flash_w);
    int unsigned r;
    logic [2:0]  key;
    logic [1:0]  kind;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 9) key = 3'($urandom_range(1, 4));
      else if ($urandom_range(0, 3) == 0) key = KeyNone;
      else key = KeyUnusedLo + 3'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      if (r < 3) kind = KindUnused;
      else if (r < 3 + flash_w) kind = KindFlash;
      else if (r < 28 + flash_w) kind = KindSecond;
      else kind = KindKey;
      queue_event(kind, key);
    end
  endtask

  // Edits the alarm or the clock so that the alarm falls zero to four seconds
  // ahead, then lets the seconds run into it with flash ticks in between.
  task automatic steer_onto_alarm(int unsigned flash_w);
    logic        set_alarm;
    int          ahead, tgt, fld, span, up;
    int          goal [3];
    set_alarm = 1'($urandom_range(0, 1));
    ahead = $urandom_range(0, 4);
    wait_idle();
    if (edit_on) begin
      queue_event(KindKey, KeySet);
      wait_idle();
    end
    while (disp_mode != (set_alarm ? ShowAlarm : ShowClock)) begin
      queue_event(KindKey, KeyNext);
      wait_idle();
    end
    queue_event(KindKey, KeySet);
    wait_idle();
    if (set_alarm)
      tgt = int'(clk_hour) * 3600 + int'(clk_min) * 60 + int'(clk_sec) + ahead;
    else
      tgt = int'(alarm_val[0]) * 3600 + int'(alarm_val[1]) * 60 + int'(alarm_val[2])
            - ahead + DayTicks;
    tgt = tgt % DayTicks;
    goal[0] = tgt / 3600;
    goal[1] = (tgt / 60) % 60;
    goal[2] = tgt % 60;
    for (fld = 0; fld < 3; fld++) begin
      while (int'(sel_field) != fld) begin
        queue_event(KindKey, KeyNext);
        wait_idle();
      end
      span = (fld == 0) ? 24 : 60;
      up = (goal[fld] - int'(edit_val[fld]) + span) % span;
      if (up * 2 <= span) repeat (up) queue_event(KindKey, KeyUp);
      else repeat (span - up) queue_event(KindKey, KeyDown);
      wait_idle();
    end
    queue_event(KindKey, KeySet);
    repeat (ahead + $urandom_range(1, 4)) begin
      queue_event(KindSecond, 3'($urandom_range(0, 7)));
      repeat ($urandom_range(0, 3)) queue_event(KindFlash, 3'($urandom_range(0, 7)));
    end
    queue_noise(flash_limit > 20 ? 30 : 6, 60);
    steered++;
  endtask

  initial begin
    logic [7:0]  limits [4];
    int unsigned flash_w [4];
    int unsigned p;
    mid_limit = 8'($urandom_range(2, 254));
    limits = '{8'd1, 8'd255, mid_limit, 8'd3};
    flash_w = '{20, 45, 25, 25};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) event_q.push_back(directed_rows[i]);
    wait_idle();

    for (p = 0; p < 4; p++) begin
      write_flash_limit(limits[p]);
      phase_count = 0;
      while (phase_count < PhaseItems) begin
        quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 15) begin
          steer_onto_alarm(flash_w[p]);
        end else begin
          queue_noise($urandom_range(5, 40), flash_w[p]);
          @(negedge clk_i);
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d events and %0d status transfers", events_taken,
             results_checked);
    $display("under flash limits 10, 1, 255, %0d and 3.", mid_limit);
    $display("Ringing started %0d times and ran out %0d times; %0d alarm approaches were steered.",
             ring_starts, ring_stops, steered);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
